// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros shared by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== hw/rtl/dcrm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcrm_pkg
// types, codes and constants of the dma clock rate monitor
// ----------------------------------------------------------------------------
package dcrm_pkg;

  localparam int TIME_W   = 48;
  localparam int FRAME_W  = 12;
  localparam int CNT_W    = 32;
  localparam int STALE_W  = 20;
  localparam int WINDOW_W = 24;
  localparam int RATE_W   = 32;
  localparam int SCALE_W  = 20;
  localparam int PROD_W   = CNT_W + SCALE_W;
  localparam int CFG_W    = 32;

  localparam logic [STALE_W-1:0]  STALE_RESET     = 20'd5000;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 24'd250000;
  localparam logic [RATE_W-1:0]   RATE_LOW_RESET  = 32'd47520;
  localparam logic [RATE_W-1:0]   RATE_HIGH_RESET = 32'd48480;
  localparam logic [SCALE_W-1:0]  RATE_SCALE      = 20'd1000000;

  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_DMA       = 2'd0,
    OP_POLL      = 2'd1,
    OP_SET_REQ   = 2'd2,
    OP_CAP_FAULT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_STALE_LIMIT = 2'd0,
    CFG_WINDOW      = 2'd1,
    CFG_RATE_LOW    = 2'd2,
    CFG_RATE_HIGH   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_QUAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t                opcode;
    logic [TIME_W-1:0]  time_us;
    logic [FRAME_W-1:0] frame_count;
    logic               request_active;
  } in_item_t;

  typedef struct packed {
    logic              transport_up;
    logic              clock_qualified;
    logic [RATE_W-1:0] measured_rate;
    logic [CNT_W-1:0]  generation;
    logic [CNT_W-1:0]  fault_total;
    logic              audio_fail;
    logic              force_mute;
    logic              playback_reset;
    logic              playback_enable;
    logic [CNT_W-1:0]  consumed_total;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic eval;
    logic mul;
    logic div_start;
    logic qual;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic meas_req;
    logic div_busy;
  } sts_t;

endpackage

// ===== hw/rtl/dcrm_div.sv =====
// ----------------------------------------------------------------------------
// dcrm_div
// restoring divider, one quotient bit per cycle, 32-bit quotient with overflow flag
// ----------------------------------------------------------------------------
module dcrm_div
  import dcrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [TIME_W-1:0] den,
  output logic              busy,
  output logic [RATE_W-1:0] quo,
  output logic              sat
);

  localparam int LO_W = PROD_W - RATE_W;

  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [RATE_W-1:0]    acc_r, acc_nxt;
  logic [TIME_W-1:0]    den_r, den_nxt;
  logic                 sat_r, sat_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [TIME_W:0]      rem_sh;
  logic [TIME_W:0]      diff;
  logic                 qbit;

  assign rem_sh = {rem_r, acc_r[RATE_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign qbit   = !diff[TIME_W];

  always_comb begin
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    den_nxt  = den_r;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      // quotient overflows 32 bits when the upper numerator part reaches den
      sat_nxt  = (den[TIME_W-1:LO_W] == '0) && (num[PROD_W-1:RATE_W] >= den[LO_W-1:0]);
      rem_nxt  = {{(TIME_W-LO_W){1'b0}}, num[PROD_W-1:RATE_W]};
      acc_nxt  = num[RATE_W-1:0];
      den_nxt  = den;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      acc_nxt = {acc_r[RATE_W-2:0], qbit};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    den_r <= den_nxt;
    sat_r <= sat_nxt;
  end

  assign busy = busy_r;
  assign quo  = acc_r;
  assign sat  = sat_r;

endmodule

// ===== hw/rtl/dcrm_dp.sv =====
// ----------------------------------------------------------------------------
// dcrm_dp
// monitor datapath: settings, transport and window state, rate measurement
// ----------------------------------------------------------------------------
module dcrm_dp
  import dcrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output out_item_t        out_data
);

  // settings
  logic [STALE_W-1:0]  stale_r;
  logic [WINDOW_W-1:0] window_r;
  logic [RATE_W-1:0]   rate_low_r;
  logic [RATE_W-1:0]   rate_high_r;

  in_item_t item_r;

  logic               ready_r, ready_nxt;
  logic               qual_r, qual_nxt;
  logic               last_valid_r, last_valid_nxt;
  logic [TIME_W-1:0]  last_time_r, last_time_nxt;
  logic               win_open_r, win_open_nxt;
  logic [TIME_W-1:0]  win_start_r, win_start_nxt;
  logic [CNT_W-1:0]   win_frames_r, win_frames_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;
  logic [CNT_W-1:0]   gen_r, gen_nxt;
  logic [CNT_W-1:0]   fault_r, fault_nxt;
  logic [CNT_W-1:0]   consumed_r, consumed_nxt;
  logic               wanted_r, wanted_nxt;
  logic               meas_r, meas_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic               fail_r, fail_nxt;
  logic               mute_r, mute_nxt;
  logic               preset_r, preset_nxt;
  logic               penable_r, penable_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  out_item_t          out_r, out_nxt;

  logic [TIME_W:0]    d_last, d_win;
  logic [TIME_W-1:0]  gap_last, gap_win;
  logic               stale_hit;
  logic               fault;
  logic [CNT_W:0]     frame_sum;
  logic               div_busy;
  logic               div_sat;
  logic [RATE_W-1:0]  div_quo;
  logic [RATE_W-1:0]  rate_val;
  logic               in_band;

  // gaps clamp to zero when time runs backwards
  assign d_last    = {1'b0, item_r.time_us} - {1'b0, last_time_r};
  assign d_win     = {1'b0, item_r.time_us} - {1'b0, win_start_r};
  assign gap_last  = d_last[TIME_W] ? '0 : d_last[TIME_W-1:0];
  assign gap_win   = d_win[TIME_W] ? '0 : d_win[TIME_W-1:0];
  assign stale_hit = gap_last > {{(TIME_W-STALE_W){1'b0}}, stale_r};
  assign frame_sum = {1'b0, win_frames_r} + {{(CNT_W-FRAME_W+1){1'b0}}, item_r.frame_count};

  always_comb begin
    fault = 1'b0;
    unique case (item_r.opcode)
      OP_DMA:       fault = !last_valid_r || stale_hit;
      OP_POLL:      fault = ready_r && (!last_valid_r || stale_hit);
      OP_SET_REQ:   fault = 1'b0;
      OP_CAP_FAULT: fault = 1'b0;
    endcase
  end

  assign rate_val = div_sat ? '1 : div_quo;
  assign in_band  = (rate_val >= rate_low_r) && (rate_val <= rate_high_r);

  always_comb begin
    ready_nxt      = ready_r;
    qual_nxt       = qual_r;
    last_valid_nxt = last_valid_r;
    last_time_nxt  = last_time_r;
    win_open_nxt   = win_open_r;
    win_start_nxt  = win_start_r;
    win_frames_nxt = win_frames_r;
    rate_nxt       = rate_r;
    gen_nxt        = gen_r;
    fault_nxt      = fault_r;
    consumed_nxt   = consumed_r;
    wanted_nxt     = wanted_r;
    meas_nxt       = meas_r;
    elapsed_nxt    = elapsed_r;
    fail_nxt       = fail_r;
    mute_nxt       = mute_r;
    preset_nxt     = preset_r;
    penable_nxt    = penable_r;
    prod_nxt       = prod_r;

    if (cmd.eval) begin
      fail_nxt    = 1'b0;
      mute_nxt    = 1'b0;
      preset_nxt  = 1'b0;
      penable_nxt = 1'b0;
      meas_nxt    = 1'b0;
      if (fault) begin
        if (ready_r) begin
          if (fault_r != '1) begin
            fault_nxt = fault_r + 1'b1;
          end
          gen_nxt  = gen_r + 1'b1;
          fail_nxt = 1'b1;
        end
        ready_nxt      = 1'b0;
        qual_nxt       = 1'b0;
        win_open_nxt   = 1'b0;
        win_frames_nxt = '0;
        mute_nxt       = 1'b1;
        preset_nxt     = 1'b1;
      end
      unique case (item_r.opcode)
        OP_DMA: begin
          if (!fault) begin
            ready_nxt = 1'b1;
          end
          last_valid_nxt = 1'b1;
          last_time_nxt  = item_r.time_us;
          if (!win_open_r || fault) begin
            win_open_nxt   = 1'b1;
            win_start_nxt  = item_r.time_us;
            win_frames_nxt = '0;
          end else begin
            win_frames_nxt = frame_sum[CNT_W] ? '1 : frame_sum[CNT_W-1:0];
            elapsed_nxt    = gap_win;
            meas_nxt       = (gap_win != '0) &&
                             (gap_win >= {{(TIME_W-WINDOW_W){1'b0}}, window_r});
          end
          consumed_nxt = consumed_r + {{(CNT_W-FRAME_W){1'b0}}, item_r.frame_count};
        end
        OP_POLL: begin
        end
        OP_SET_REQ: begin
          wanted_nxt  = item_r.request_active;
          preset_nxt  = 1'b1;
          penable_nxt = item_r.request_active && ready_r && qual_r;
        end
        OP_CAP_FAULT: begin
          gen_nxt  = gen_r + 1'b1;
          fail_nxt = 1'b1;
        end
      endcase
    end

    if (cmd.mul) begin
      prod_nxt       = PROD_W'(win_frames_r) * PROD_W'(RATE_SCALE);
      win_frames_nxt = '0;
      win_start_nxt  = item_r.time_us;
    end

    if (cmd.qual) begin
      rate_nxt = rate_val;
      if (qual_r && !in_band) begin
        gen_nxt  = gen_r + 1'b1;
        fail_nxt = 1'b1;
      end
      if (qual_r != in_band) begin
        preset_nxt  = 1'b1;
        penable_nxt = wanted_r && ready_r && in_band;
      end
      qual_nxt = in_band;
      if (!in_band) begin
        mute_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_nxt.transport_up    = ready_r;
    out_nxt.clock_qualified = qual_r;
    out_nxt.measured_rate   = rate_r;
    out_nxt.generation      = gen_r;
    out_nxt.fault_total     = fault_r;
    out_nxt.audio_fail      = fail_r;
    out_nxt.force_mute      = mute_r;
    out_nxt.playback_reset  = preset_r;
    out_nxt.playback_enable = preset_r && penable_r;
    out_nxt.consumed_total  = consumed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r     <= STALE_RESET;
      window_r    <= WINDOW_RESET;
      rate_low_r  <= RATE_LOW_RESET;
      rate_high_r <= RATE_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STALE_LIMIT: stale_r     <= cfg_data[STALE_W-1:0];
        CFG_WINDOW:      window_r    <= cfg_data[WINDOW_W-1:0];
        CFG_RATE_LOW:    rate_low_r  <= cfg_data[RATE_W-1:0];
        CFG_RATE_HIGH:   rate_high_r <= cfg_data[RATE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r      <= 1'b0;
      qual_r       <= 1'b0;
      last_valid_r <= 1'b0;
      last_time_r  <= '0;
      win_open_r   <= 1'b0;
      win_start_r  <= '0;
      win_frames_r <= '0;
      rate_r       <= '0;
      gen_r        <= '0;
      fault_r      <= '0;
      consumed_r   <= '0;
      wanted_r     <= 1'b0;
      meas_r       <= 1'b0;
    end else begin
      ready_r      <= ready_nxt;
      qual_r       <= qual_nxt;
      last_valid_r <= last_valid_nxt;
      last_time_r  <= last_time_nxt;
      win_open_r   <= win_open_nxt;
      win_start_r  <= win_start_nxt;
      win_frames_r <= win_frames_nxt;
      rate_r       <= rate_nxt;
      gen_r        <= gen_nxt;
      fault_r      <= fault_nxt;
      consumed_r   <= consumed_nxt;
      wanted_r     <= wanted_nxt;
      meas_r       <= meas_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
    elapsed_r <= elapsed_nxt;
    fail_r    <= fail_nxt;
    mute_r    <= mute_nxt;
    preset_r  <= preset_nxt;
    penable_r <= penable_nxt;
    prod_r    <= prod_nxt;
  end

  dcrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (elapsed_r),
    .busy  (div_busy),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  assign sts.meas_req = meas_r;
  assign sts.div_busy = div_busy;
  assign out_data     = out_r;

endmodule

// ===== hw/rtl/dcrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcrm_ctrl
// sequencer: item intake, measurement steps and result register handshake
// ----------------------------------------------------------------------------
module dcrm_ctrl
  import dcrm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (sts.meas_req) begin
          cmd.mul   = 1'b1;
          state_nxt = ST_DIV_START;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_QUAL;
        end
      end
      ST_QUAL: begin
        cmd.qual  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // result register free or being emptied this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/dma_clock_rate_monitor_top.sv =====
// one item at a time passes the eval, mul and out states; a dma event that closes
// a rate window adds div_start, div (32-step frames*1e6/elapsed divider) and qual
// the result register lets the next item in while a result waits
// reset: synchronous rst_n clears control, window and counter state, but not the
// data registers; settings return to defaults
// ----------------------------------------------------------------------------
// dma_clock_rate_monitor_top
// audio dma transport and clock rate monitor with configuration port
// ----------------------------------------------------------------------------
module dma_clock_rate_monitor_top
  import dcrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  dcrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dcrm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/dcrm_checker.sv =====
// ----------------------------------------------------------------------------
// dcrm_checker
// port-level checks of the monitor, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcrm_checker
  import dcrm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result stays put
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

  // one item at a time: intake closes right after a transfer
  `ASSERT_CLK(a_in_one_at_a_time, clk, rst_n, in_valid && !in_stall |=> in_stall)

  // enable only comes with a playback reset
  `ASSERT_NEVER(a_enable_needs_reset, clk, rst_n,
    out_valid && out_data.playback_enable && !out_data.playback_reset)

  // a qualified clock implies the transport is up
  `ASSERT_NEVER(a_qual_needs_up, clk, rst_n,
    out_valid && out_data.clock_qualified && !out_data.transport_up)

endmodule

bind dma_clock_rate_monitor_top dcrm_checker u_dcrm_checker (.*);
